>>> src/wcg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcg_pkg: window coefficient generator shared definitions
// Widths, window weights, stage interface types and the quarter-wave cosine
// table, built at elaboration with a 62-bit fixed-point series.
// ----------------------------------------------------------------------------
package wcg_pkg;

  localparam int unsigned INDEX_W     = 12;
  localparam int unsigned PHASE_BITS  = 12;
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned TYPE_W      = 2;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = LEN_W;
  localparam int unsigned MAX_LENGTH  = 4096;
  localparam int unsigned DIVISOR_W   = $clog2(MAX_LENGTH);

  // dividend is index << PHASE_BITS, two restoring steps per stage
  localparam int unsigned DIV_W      = INDEX_W + PHASE_BITS;
  localparam int unsigned DIV_STAGES = DIV_W / 2;

  localparam int unsigned QUARTER    = 1 << (PHASE_BITS - 2);
  localparam int unsigned COS_DEPTH  = QUARTER + 1;
  localparam int unsigned COS_ADDR_W = PHASE_BITS - 1;
  localparam int unsigned CMAG_W     = 15;
  localparam int unsigned COS_W      = 16;

  localparam int unsigned A0_W = 16;
  localparam int unsigned A1_W = 15;
  localparam int unsigned A2_W = 12;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(32768);

  // input register, divider, cosine address/read, multiply, sum, output
  localparam int unsigned LATENCY = DIV_STAGES + 6;

  typedef enum logic [TYPE_W-1:0] {
    WIN_RECT     = 2'd0,
    WIN_HAMMING  = 2'd1,
    WIN_HANN     = 2'd2,
    WIN_BLACKMAN = 2'd3
  } win_type_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_TYPE   = 1'b0,
    REG_WINDOW_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                  valid;
    logic [PHASE_BITS-1:0] phase;
  } phase_req_t;

  typedef struct packed {
    logic                    valid;
    logic signed [COS_W-1:0] c1;
    logic signed [COS_W-1:0] c2;
  } cos_pair_t;

  typedef logic [COS_DEPTH-1:0][CMAG_W-1:0] cos_table_t;

  function automatic logic [A0_W-1:0] weight_a0(input win_type_t t);
    logic [A0_W-1:0] w;
    unique case (t)
      WIN_RECT:     w = A0_W'(32768);
      WIN_HAMMING:  w = A0_W'(17695);
      WIN_HANN:     w = A0_W'(16384);
      WIN_BLACKMAN: w = A0_W'(13763);
      default:      w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [A1_W-1:0] weight_a1(input win_type_t t);
    logic [A1_W-1:0] w;
    unique case (t)
      WIN_RECT:     w = '0;
      WIN_HAMMING:  w = A1_W'(15073);
      WIN_HANN:     w = A1_W'(16384);
      WIN_BLACKMAN: w = A1_W'(16384);
      default:      w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [A2_W-1:0] weight_a2(input win_type_t t);
    logic [A2_W-1:0] w;
    unique case (t)
      WIN_BLACKMAN: w = A2_W'(2621);
      default:      w = '0;
    endcase
    return w;
  endfunction

  // elaboration-time helpers for the cosine table
  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
  localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // floor(a / b), restoring long division
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], a[i]};
      if (rem >= {1'b0, b}) begin
        rem    = rem - {1'b0, b};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] series_q62(input logic [63:0] x, input logic odd);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] n;
    x2   = mul_q62(x, x);
    term = odd ? x : ONE_Q62;
    sum  = term;
    for (int k = 1; k <= 12; k++) begin
      if (term != 64'd0) begin
        n    = odd ? 64'(2 * k) : 64'(2 * k - 1);
        term = udiv64(mul_q62(term, x2), n * (n + 64'd1));
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

  // |round(32767 * cos(2*pi*p / 2^PHASE_BITS))|
  function automatic logic [CMAG_W-1:0] cos_mag_q15(input int unsigned p);
    logic [63:0] qtr;
    logic [63:0] r;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] v;
    logic [63:0] t;
    logic [1:0]  quad;
    logic        want_sin;
    qtr      = 64'd1 << (PHASE_BITS - 2);
    quad     = 2'((p >> (PHASE_BITS - 2)) & 3);
    r        = 64'(p) & (qtr - 64'd1);
    want_sin = quad[0];
    m        = r;
    if (r > (qtr >> 1)) begin
      m        = qtr - r;
      want_sin = !want_sin;
    end
    x = mul_q62(PI_Q62, m << (63 - PHASE_BITS));
    v = series_q62(x, want_sin);
    t = mul_q62(v, 64'd32767 << 20);
    return CMAG_W'((t + (64'd1 << 19)) >> 20);
  endfunction

  // fills both ends of the table at once
  function automatic cos_table_t build_cos_table();
    cos_table_t tbl;
    for (int k = 0; k <= QUARTER / 2; k++) begin
      tbl[k]           = cos_mag_q15(k);
      tbl[QUARTER - k] = cos_mag_q15(QUARTER - k);
    end
    return tbl;
  endfunction

  localparam cos_table_t COS_TABLE = build_cos_table();

endpackage
`default_nettype wire

>>> src/wcg_phase_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcg_phase_div: pipelined phase divider
// Restoring division of index << PHASE_BITS by N-1, two quotient bits per
// stage; the low PHASE_BITS of the quotient form the phase.
// ----------------------------------------------------------------------------
module wcg_phase_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [wcg_pkg::INDEX_W-1:0]     in_index,
  input  logic [wcg_pkg::DIVISOR_W-1:0]   divisor,
  output wcg_pkg::phase_req_t             out
);
  import wcg_pkg::*;

  typedef struct packed {
    logic [DIVISOR_W-1:0] rem;
    logic [DIV_W-1:0]     work;
  } div_state_t;

  function automatic div_state_t div_step(input div_state_t s,
                                          input logic [DIVISOR_W-1:0] d);
    logic [DIVISOR_W:0] trial;
    div_state_t         o;
    trial  = {s.rem, s.work[DIV_W-1]};
    o.work = {s.work[DIV_W-2:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      o.rem     = DIVISOR_W'(trial - {1'b0, d});
      o.work[0] = 1'b1;
    end else begin
      o.rem = trial[DIVISOR_W-1:0];
    end
    return o;
  endfunction

  div_state_t            st  [DIV_STAGES+1];
  div_state_t            nxt [DIV_STAGES];
  logic [DIV_STAGES:0]   vld;

  always_comb begin
    for (int g = 0; g < DIV_STAGES; g++) begin
      nxt[g] = div_step(div_step(st[g], divisor), divisor);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DIV_STAGES-1:0], in_valid};
    end
    st[0].rem  <= '0;
    st[0].work <= {in_index, PHASE_BITS'(0)};
    for (int g = 0; g < DIV_STAGES; g++) begin
      st[g+1] <= nxt[g];
    end
  end

  assign out.valid = vld[DIV_STAGES];
  assign out.phase = st[DIV_STAGES].work[PHASE_BITS-1:0];

endmodule
`default_nettype wire

>>> src/wcg_cos_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcg_cos_unit: cosine lookup
// Folds phase p and 2p onto the quarter-wave table, then reads both
// magnitudes and applies the quadrant sign. Two register stages.
// ----------------------------------------------------------------------------
module wcg_cos_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  wcg_pkg::phase_req_t  req,
  output wcg_pkg::cos_pair_t   out
);
  import wcg_pkg::*;

  typedef struct packed {
    logic [COS_ADDR_W-1:0] addr;
    logic                  neg;
  } cos_addr_t;

  function automatic cos_addr_t fold(input logic [PHASE_BITS-1:0] ph);
    cos_addr_t             a;
    logic [COS_ADDR_W-1:0] r;
    r = {1'b0, ph[PHASE_BITS-3:0]};
    // odd quadrants read the table mirrored
    if (ph[PHASE_BITS-2]) begin
      a.addr = COS_ADDR_W'(QUARTER) - r;
    end else begin
      a.addr = r;
    end
    a.neg = ph[PHASE_BITS-1] ^ ph[PHASE_BITS-2];
    return a;
  endfunction

  logic      a_valid;
  cos_addr_t a1;
  cos_addr_t a2;

  logic [CMAG_W-1:0] mag1;
  logic [CMAG_W-1:0] mag2;
  logic              c_valid;
  logic signed [COS_W-1:0] c1;
  logic signed [COS_W-1:0] c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= req.valid;
    end
    a1 <= fold(req.phase);
    a2 <= fold({req.phase[PHASE_BITS-2:0], 1'b0});
  end

  assign mag1 = COS_TABLE[a1.addr];
  assign mag2 = COS_TABLE[a2.addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= a_valid;
    end
    c1 <= a1.neg ? -$signed({1'b0, mag1}) : $signed({1'b0, mag1});
    c2 <= a2.neg ? -$signed({1'b0, mag2}) : $signed({1'b0, mag2});
  end

  assign out.valid = c_valid;
  assign out.c1    = c1;
  assign out.c2    = c2;

endmodule
`default_nettype wire

>>> src/wcg_combine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcg_combine: weighted sum and clamp
// a0*32768 - a1*c1 + a2*c2 + 16384, floor-shifted by 15 and clamped to
// 0..32768. Multiply, sum and output register stages.
// ----------------------------------------------------------------------------
module wcg_combine (
  input  logic                        clk,
  input  logic                        rst,
  input  wcg_pkg::cos_pair_t          cos_in,
  input  wcg_pkg::win_type_t          window_type,
  output logic                        done,
  output logic [wcg_pkg::COEF_W-1:0]  coefficient
);
  import wcg_pkg::*;

  localparam int unsigned PROD_W = 32;
  localparam int unsigned SUM_W  = 33;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(16384);

  logic signed [PROD_W-1:0] a1_ext;
  logic signed [PROD_W-1:0] a2_ext;
  logic signed [PROD_W-1:0] c1_ext;
  logic signed [PROD_W-1:0] c2_ext;

  logic                     m_valid;
  logic signed [PROD_W-1:0] p1;
  logic signed [PROD_W-1:0] p2;

  logic signed [SUM_W-1:0]  a0_term;
  logic signed [SUM_W-1:0]  sum_next;
  logic                     s_valid;
  logic signed [SUM_W-1:0]  sum;

  logic [SUM_W-16:0]        q;
  logic [COEF_W-1:0]        coefficient_next;

  assign a1_ext = $signed({{(PROD_W-A1_W){1'b0}}, weight_a1(window_type)});
  assign a2_ext = $signed({{(PROD_W-A2_W){1'b0}}, weight_a2(window_type)});
  assign c1_ext = {{(PROD_W-COS_W){cos_in.c1[COS_W-1]}}, cos_in.c1};
  assign c2_ext = {{(PROD_W-COS_W){cos_in.c2[COS_W-1]}}, cos_in.c2};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= cos_in.valid;
    end
    p1 <= a1_ext * c1_ext;
    p2 <= a2_ext * c2_ext;
  end

  assign a0_term  = $signed({2'b00, weight_a0(window_type), 15'd0});
  assign sum_next = a0_term - {p1[PROD_W-1], p1} + {p2[PROD_W-1], p2} + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= m_valid;
    end
    sum <= sum_next;
  end

  assign q = sum[SUM_W-1:15];

  always_comb begin
    priority if (q[SUM_W-16]) begin
      coefficient_next = '0;
    end else if (q[SUM_W-17:0] > {1'b0, COEF_ONE}) begin
      coefficient_next = COEF_ONE;
    end else begin
      coefficient_next = q[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s_valid;
    end
    coefficient <= coefficient_next;
  end

endmodule
`default_nettype wire

>>> src/window_coefficient_generator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// window_coefficient_generator_core: window coefficient generator
// One request per clock, no stall on either side: busy is low except during
// reset. Each request returns its coefficient with done after the input
// register, 12 divider stages resolving two phase quotient bits each, cosine
// fold and table read, multiply, sum and clamp. Results leave in request
// order and cannot be held off. Configuration writes (window type, length N)
// are taken at once and reach requests in flight; the user, not the block,
// must see that they apply only to requests issued after the pipeline drains.
// ----------------------------------------------------------------------------
module window_coefficient_generator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [wcg_pkg::INDEX_W-1:0]       sample_index,
  output logic                              done,
  output logic [wcg_pkg::COEF_W-1:0]        coefficient,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wcg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [wcg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wcg_pkg::*;

  win_type_t            window_type;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIVISOR_W-1:0] divisor_next;

  phase_req_t           phase_req;
  cos_pair_t            cos_pair;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // N clamped to 2..MAX_LENGTH, stored as N-1
  always_comb begin
    priority if (cfg_data < LEN_W'(2)) begin
      divisor_next = DIVISOR_W'(1);
    end else if (cfg_data > LEN_W'(MAX_LENGTH)) begin
      divisor_next = DIVISOR_W'(MAX_LENGTH - 1);
    end else begin
      divisor_next = DIVISOR_W'(cfg_data - LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_type <= WIN_RECT;
      divisor     <= DIVISOR_W'(MAX_LENGTH - 1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_TYPE:   window_type <= win_type_t'(cfg_data[TYPE_W-1:0]);
        REG_WINDOW_LENGTH: divisor     <= divisor_next;
        default: ;
      endcase
    end
  end

  wcg_phase_div u_phase_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .in_index (sample_index),
    .divisor  (divisor),
    .out      (phase_req)
  );

  wcg_cos_unit u_cos_unit (
    .clk (clk),
    .rst (rst),
    .req (phase_req),
    .out (cos_pair)
  );

  wcg_combine u_combine (
    .clk         (clk),
    .rst         (rst),
    .cos_in      (cos_pair),
    .window_type (window_type),
    .done        (done),
    .coefficient (coefficient)
  );

endmodule
`default_nettype wire

>>> src/wcg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wcg_checker: port-level checks for the window coefficient generator
// Fixed request-to-result latency and output range.
// ----------------------------------------------------------------------------
module wcg_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic [wcg_pkg::COEF_W-1:0]        coefficient
);
  import wcg_pkg::*;

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (coefficient <= COEF_ONE))
    else $error("coefficient above 1.0");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  a_request_answered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("request not answered at fixed latency");

endmodule

bind window_coefficient_generator_core wcg_checker u_wcg_checker (.*);
`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: window coefficient generator testbench
// Sends sample indices to the core under several window types and lengths.
// An in-bench fixed-point predictor works out each coefficient when its
// request is taken, and the result strobe is checked against it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import wcg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEM_TARGET = 1550;
  localparam int unsigned QUIET_FROM  = 1300;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [INDEX_W-1:0]     sample_index = '0;
  logic                   done;
  logic [COEF_W-1:0]      coefficient;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic [COEF_W-1:0] expected_coefs[$];
  win_type_t         cur_type = WIN_RECT;
  logic [LEN_W-1:0]  cur_length = LEN_W'(4096);
  int unsigned       mismatches = 0;
  int unsigned       cycle_count = 0;
  int unsigned       sent = 0;

  window_coefficient_generator_core uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample_index (sample_index),
    .done         (done),
    .coefficient  (coefficient),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // floor(a * b / 2^62)
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = {64'd0, a} * {64'd0, b};
    return wide[125:62];
  endfunction

  // Taylor sum on [0, pi/4]: sine if odd_terms, else cosine
  function automatic logic [63:0] q62_taylor(input logic [63:0] x, input logic odd_terms);
    logic [63:0] xsq;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] n;
    xsq  = q62_mul(x, x);
    term = odd_terms ? x : 64'h4000000000000000;
    acc  = term;
    for (int k = 1; k <= 12; k++) begin
      if (term != 64'd0) begin
        n    = odd_terms ? 64'(2 * k) : 64'(2 * k - 1);
        term = q62_mul(term, xsq) / (n * (n + 64'd1));
        if (k % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return acc;
  endfunction

  // round(32767 * cos(2*pi*phase / 4096)), halves away from zero
  function automatic longint cos_term(input logic [PHASE_BITS-1:0] phase);
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] m;
    logic [63:0] v;
    logic [63:0] scaled;
    logic        use_sin;
    longint      mag;
    quad    = phase[PHASE_BITS-1 -: 2];
    r       = 64'(phase[PHASE_BITS-3:0]);
    use_sin = quad[0];
    m       = r;
    if (r > 64'(QUARTER / 2)) begin
      m       = 64'(QUARTER) - r;
      use_sin = !use_sin;
    end
    v      = q62_taylor(q62_mul(64'hC90FDAA22168C235, m << (63 - PHASE_BITS)), use_sin);
    scaled = q62_mul(v, 64'd32767 << 20);
    mag    = longint'((scaled + (64'd1 << 19)) >> 20);
    return (quad == 2'd1 || quad == 2'd2) ? -mag : mag;
  endfunction

  function automatic logic [COEF_W-1:0] calc_window_coef(input win_type_t wt,
                                                         input logic [LEN_W-1:0] len,
                                                         input logic [INDEX_W-1:0] idx);
    longint n;
    longint a0;
    longint a1;
    longint a2;
    longint acc;
    longint res;
    logic [PHASE_BITS-1:0] phase;
    n = longint'(len);
    if (n < 2) n = 2;
    if (n > MAX_LENGTH) n = MAX_LENGTH;
    case (wt)
      WIN_HAMMING:  begin a0 = 17695; a1 = 15073; a2 = 0;    end
      WIN_HANN:     begin a0 = 16384; a1 = 16384; a2 = 0;    end
      WIN_BLACKMAN: begin a0 = 13763; a1 = 16384; a2 = 2621; end
      default:      begin a0 = 32768; a1 = 0;     a2 = 0;    end
    endcase
    if (wt == WIN_RECT) return COEF_ONE;
    phase = PHASE_BITS'((longint'(idx) << PHASE_BITS) / (n - 1));
    acc   = a0 * 32768 - a1 * cos_term(phase) + a2 * cos_term(phase << 1) + 16384;
    res   = acc >>> 15;
    if (res < 0) res = 0;
    if (res > 32768) res = 32768;
    return COEF_W'(res);
  endfunction

  // request capture and result check
  always @(posedge clk) begin
    logic [COEF_W-1:0] want;
    if (!rst) begin
      if (start && !busy) begin
        expected_coefs.push_back(calc_window_coef(cur_type, cur_length, sample_index));
      end
      if (done) begin
        if (expected_coefs.size() == 0) begin
          $display("%0t: unexpected coefficient: expected none, actual %0d",
                   $time, coefficient);
          mismatches++;
        end else begin
          want = expected_coefs.pop_front();
          if (coefficient !== want) begin
            $display("%0t: coefficient mismatch: expected %0d, actual %0d",
                     $time, want, coefficient);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic issue_request(input logic [INDEX_W-1:0] idx);
    @(negedge clk);
    start        <= 1'b1;
    sample_index <= idx;
    do begin
      @(posedge clk);
    end while (busy);
    sent++;
  endtask

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_coefs.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    if (which == REG_WINDOW_TYPE) begin
      cur_type = win_type_t'(value[TYPE_W-1:0]);
    end else begin
      cur_length = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_window(input win_type_t wt, input logic [LEN_W-1:0] len);
    drain();
    write_reg(REG_WINDOW_TYPE, CFG_DATA_W'(wt));
    write_reg(REG_WINDOW_LENGTH, len);
  endtask

  task automatic test_rectangular();
    issue_request(12'd0);
    issue_request(12'd2048);
    issue_request(12'hFFF);
    set_window(WIN_RECT, 13'd2);
    issue_request(12'hFFF);
  endtask

  // length below two, above the maximum, and indices past the end
  task automatic test_length_limits();
    set_window(WIN_HANN, 13'd0);
    issue_request(12'd0);
    issue_request(12'd1);
    set_window(WIN_HANN, 13'd1);
    issue_request(12'hFFF);
    set_window(WIN_HANN, 13'h1FFF);
    issue_request(12'd0);
    issue_request(12'hFFF);
    set_window(WIN_HANN, 13'd4097);
    issue_request(12'd2048);
  endtask

  task automatic test_window_shapes();
    set_window(WIN_HAMMING, 13'd2);
    issue_request(12'd0);
    issue_request(12'd1);
    set_window(WIN_HAMMING, 13'd4096);
    issue_request(12'd2047);
    set_window(WIN_BLACKMAN, 13'd4096);
    issue_request(12'd0);
    issue_request(12'd2048);
    issue_request(12'hFFF);
    set_window(WIN_BLACKMAN, 13'd3);
    issue_request(12'd1);
    issue_request(12'd3);
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    logic [LEN_W-1:0] edges[8] = '{13'd0, 13'd1, 13'd2, 13'd3,
                                   13'd4095, 13'd4096, 13'd4097, 13'h1FFF};
    case ($urandom_range(0, 9))
      0, 1:    return edges[$urandom_range(0, 7)];
      2:       return LEN_W'($urandom_range(0, 8191));
      3, 4:    return LEN_W'($urandom_range(2, 16));
      default: return LEN_W'($urandom_range(2, 4096));
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index(input logic [LEN_W-1:0] len);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return (len < 2) ? INDEX_W'(1) : INDEX_W'(len - 1);
      3:       return INDEX_W'(len >> 1);
      default: return INDEX_W'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic test_random_windows();
    int unsigned      burst;
    logic             gaps_on;
    logic [LEN_W-1:0] len;
    while (sent < ITEM_TARGET) begin
      len = pick_length();
      drain();
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_WINDOW_TYPE, CFG_DATA_W'($urandom_range(0, 8191)));
        write_reg(REG_WINDOW_LENGTH, len);
      end else begin
        write_reg(REG_WINDOW_LENGTH, len);
        write_reg(REG_WINDOW_TYPE, CFG_DATA_W'($urandom_range(0, 8191)));
      end
      burst   = $urandom_range(8, 64);
      gaps_on = (sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      repeat (burst) begin
        if (gaps_on && $urandom_range(0, 3) == 0) begin
          hold_off($urandom_range(1, 17));
        end
        issue_request(pick_index(cur_length));
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_rectangular();
    test_length_limits();
    test_window_shapes();
    test_random_windows();
    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
